>>> sv/swcp_pkg.sv
// swcp_pkg: shared constants and controller/datapath handshake types for
// the swapchain cycle predictor. No dependencies.
`default_nettype none

package swcp_pkg;

    localparam int DEF_TABLE_DEPTH = 6;
    localparam int DEF_FRAME_BITS  = 64;
    localparam int DEF_TAG_BITS    = 32;

    localparam int          THR_W     = 3;
    localparam int          SEEN_W    = 3;
    localparam logic [2:0]  THR_RESET = 3'd3;
    localparam logic [2:0]  SEEN_MAX  = 3'd7;

    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    typedef struct packed {
        logic load;     // latch input word, compare tags
        logic exec;     // apply predict / report update
        logic shift;    // drop oldest entry by one
        logic finish;   // load output register
    } swcp_cmd_t;

    typedef struct packed {
        logic need_shift;
        logic shift_last;
        logic out_free;
    } swcp_sts_t;

endpackage

`default_nettype wire

>>> sv/swcp_ctrl.sv
// swcp_ctrl: sequencer for the swapchain cycle predictor.
// Depends on swcp_pkg (command and status types).
`default_nettype none

module swcp_ctrl
    import swcp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire swcp_sts_t sts,
    output swcp_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.need_shift ? ST_SHIFT : ST_FIN;
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
                if (sts.shift_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/swcp_datapath.sv
// swcp_datapath: entry table, cycle tracking, threshold register and
// output register of the swapchain cycle predictor. Depends on swcp_pkg.
`default_nettype none

module swcp_datapath
    import swcp_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int FRAME_BITS  = DEF_FRAME_BITS,
    parameter int TAG_BITS    = DEF_TAG_BITS,
    localparam int S_DATA_W   = ((TAG_BITS + FRAME_BITS + 1 + 7) / 8) * 8,
    localparam int M_DATA_W   = ((FRAME_BITS + 3 + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [THR_W-1:0]      cfg_wdata,
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    input  wire logic [0:0]            s_tuser,
    input  wire swcp_cmd_t             cmd,
    output swcp_sts_t                  sts,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_DATA_W-1:0]        m_tdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // input word fields
    logic [TAG_BITS-1:0]   s_tag;
    logic [FRAME_BITS-1:0] s_frame;
    logic                  s_pred;

    assign s_tag   = s_tdata[TAG_BITS-1:0];
    assign s_frame = s_tdata[TAG_BITS +: FRAME_BITS];
    assign s_pred  = s_tdata[TAG_BITS + FRAME_BITS];

    logic [TAG_BITS-1:0]   tag_reg   [TABLE_DEPTH];
    logic [TAG_BITS-1:0]   tag_next  [TABLE_DEPTH];
    logic [FRAME_BITS-1:0] frame_reg [TABLE_DEPTH];
    logic [FRAME_BITS-1:0] frame_next[TABLE_DEPTH];

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic              pos_none_reg, pos_none_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [THR_W-1:0]  thr_reg, thr_next;
    logic [IDX_W-1:0]  shift_cnt_reg, shift_cnt_next;

    logic                  kind_reg;
    logic [TAG_BITS-1:0]   tag_in_reg;
    logic [FRAME_BITS-1:0] frame_in_reg;
    logic                  pred_reg;
    logic [TABLE_DEPTH-1:0] eq_vec_reg, eq_vec_next;

    logic                  res_show_reg, res_show_next;
    logic                  res_mis_reg, res_mis_next;
    logic [FRAME_BITS-1:0] res_frame_reg, res_frame_next;

    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg, m_data_next;

    logic [THR_W-1:0]      thr_eff;
    logic                  match_found;
    logic [IDX_W-1:0]      match_idx;
    logic [IDX_W-1:0]      rd_addr;
    logic [FRAME_BITS-1:0] rd_frame;
    logic [IDX_W-1:0]      step_pos;
    logic                  step_ok;
    logic                  step_eq;
    logic                  restart;
    logic                  same;
    logic [CNT_W-1:0]      pos_wide;
    logic [CNT_W-1:0]      probe;
    logic [IDX_W-1:0]      slot;
    logic                  pv;

    assign thr_eff = (thr_reg == '0) ? THR_W'(1) : thr_reg;

    // first matching entry
    always_comb begin
        match_found = 1'b0;
        match_idx   = '0;
        for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
            if (eq_vec_reg[k]) begin
                match_found = 1'b1;
                match_idx   = IDX_W'(k);
            end
        end
    end

    assign rd_addr  = cmd.exec ? match_idx : pos_reg;
    assign rd_frame = frame_reg[rd_addr];
    assign pos_wide = CNT_W'(pos_reg);

    // next position when stepping through a confirmed cycle
    always_comb begin
        step_ok  = (count_reg != '0);
        step_pos = '0;
        if (step_ok && !pos_none_reg && (pos_wide < count_reg)
                && (pos_wide + CNT_W'(1) != count_reg)) begin
            step_pos = pos_reg + IDX_W'(1);
        end
    end
    assign step_eq = eq_vec_reg[step_pos];
    assign same    = match_found && (rd_frame == frame_in_reg);

    always_comb begin
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            eq_vec_next[k] = (tag_reg[k] == s_tag) && (CNT_W'(k) < count_reg);
        end
    end

    always_comb begin
        tag_next       = tag_reg;
        frame_next     = frame_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        pos_none_next  = pos_none_reg;
        seen_next      = seen_reg;
        shift_cnt_next = shift_cnt_reg;
        res_show_next  = res_show_reg;
        res_mis_next   = res_mis_reg;
        res_frame_next = res_frame_reg;
        restart        = 1'b0;
        probe          = '0;
        slot           = '0;

        if (cmd.shift) begin
            for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
                tag_next[k]   = tag_reg[k + 1];
                frame_next[k] = frame_reg[k + 1];
            end
            shift_cnt_next = shift_cnt_reg - IDX_W'(1);
        end

        if (cmd.exec) begin
            if (kind_reg == KIND_PREDICT) begin
                if (seen_reg >= thr_eff) begin
                    restart = !step_ok || !step_eq;
                    pos_next      = step_pos;
                    pos_none_next = 1'b0;
                end else if (seen_reg != '0) begin
                    pos_next      = step_pos;
                    pos_none_next = 1'b0;
                    if (step_ok && (step_pos == '0) && (seen_reg != SEEN_MAX)) begin
                        seen_next = seen_reg + SEEN_W'(1);
                    end
                    restart = !step_ok || !step_eq;
                end else if (match_found) begin
                    // repeat found: drop older entries, first cycle seen
                    count_next     = count_reg - CNT_W'(match_idx);
                    pos_next       = '0;
                    pos_none_next  = 1'b0;
                    seen_next      = SEEN_W'(1);
                    shift_cnt_next = match_idx;
                end else begin
                    probe = pos_none_reg ? '0 : pos_wide + CNT_W'(1);
                    slot  = probe[IDX_W-1:0];
                    if (probe >= count_reg) begin
                        if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                            slot = '0;
                        end else begin
                            slot             = count_reg[IDX_W-1:0];
                            frame_next[slot] = '0;
                            count_next       = count_reg + CNT_W'(1);
                        end
                    end
                    tag_next[slot] = tag_in_reg;
                    pos_next       = slot;
                    pos_none_next  = 1'b0;
                end
                if (restart) begin
                    if (count_reg == '0) begin
                        frame_next[0] = '0;
                    end
                    count_next    = CNT_W'(1);
                    tag_next[0]   = tag_in_reg;
                    pos_next      = '0;
                    pos_none_next = 1'b0;
                    seen_next     = '0;
                end
            end else begin
                res_show_next  = !pred_reg || !same;
                res_mis_next   = pred_reg && !same;
                res_frame_next = (!pred_reg || !same) ? frame_in_reg : '0;
                if (!same) begin
                    if (match_found) begin
                        frame_next[match_idx] = frame_in_reg;
                    end
                    if (seen_reg > SEEN_W'(1)) begin
                        seen_next = SEEN_W'(1);
                    end
                end
            end
        end
    end

    assign pv = (seen_reg >= thr_eff) && !pos_none_reg && (pos_wide < count_reg);

    always_comb begin
        thr_next     = cfg_we ? cfg_wdata : thr_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.finish) begin
            m_valid_next = 1'b1;
            if (kind_reg == KIND_PREDICT) begin
                m_data_next = M_DATA_W'({(pv ? rd_frame : {FRAME_BITS{1'b0}}),
                                         1'b0, 1'b0, pv});
            end else begin
                m_data_next = M_DATA_W'({res_frame_reg, res_mis_reg,
                                         res_show_reg, 1'b0});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            pos_reg       <= '0;
            pos_none_reg  <= 1'b1;
            seen_reg      <= '0;
            thr_reg       <= THR_RESET;
            shift_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            pos_none_reg  <= pos_none_next;
            seen_reg      <= seen_next;
            thr_reg       <= thr_next;
            shift_cnt_reg <= shift_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg       <= tag_next;
        frame_reg     <= frame_next;
        res_show_reg  <= res_show_next;
        res_mis_reg   <= res_mis_next;
        res_frame_reg <= res_frame_next;
        m_data_reg    <= m_data_next;
        if (cmd.load) begin
            kind_reg     <= s_tuser[0];
            tag_in_reg   <= s_tag;
            frame_in_reg <= s_frame;
            pred_reg     <= s_pred;
            eq_vec_reg   <= eq_vec_next;
        end
    end

    assign sts.need_shift = (kind_reg == KIND_PREDICT) && (seen_reg == '0)
                            && match_found && (match_idx != '0);
    assign sts.shift_last = (shift_cnt_reg == IDX_W'(1));
    assign sts.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

>>> sv/swapchain_cycle_predictor.sv
// swapchain_cycle_predictor: top level, joins sequencer and datapath.
// Depends on swcp_pkg, swcp_ctrl, swcp_datapath.
//
// Usage: one word on the s_ channel per presented sync object (s_tuser = 0,
// predict request) or per rendered frame (s_tuser = 1, report). Every
// accepted word yields exactly one word on the m_ channel, in order.
// cfg_we/cfg_wdata write the predict threshold (0 acts as 1); write only
// while no word is in flight.
// Sequence: a word is taken in IDLE, updated in the execute step and loaded
// into the output register in the finish step; a new word is taken only
// once the block is back in IDLE. A predict request that finds a repeat of
// an older tag drops the older entries one per cycle in a shift step
// between execute and finish.
// The output register lets the next word be accepted and executed while a
// result waits; a low m_tready then stalls the block in its finish step.
// Reset (aresetn low, synchronous) empties the table, clears the cycle
// count and sets the threshold to 3.
`default_nettype none

module swapchain_cycle_predictor
    import swcp_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int FRAME_BITS  = DEF_FRAME_BITS,
    parameter int TAG_BITS    = DEF_TAG_BITS,
    localparam int S_DATA_W   = ((TAG_BITS + FRAME_BITS + 1 + 7) / 8) * 8,
    localparam int M_DATA_W   = ((FRAME_BITS + 3 + 7) / 8) * 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [THR_W-1:0]    cfg_wdata,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // sync_tag, frame_word, predicting_now, zero pad
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // kind
    input  wire logic [0:0]          s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // predict_valid, show_frame, mispredicted, frame_out, zero pad
    output logic [M_DATA_W-1:0]      m_tdata
);

    swcp_cmd_t cmd;
    swcp_sts_t sts;

    swcp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    swcp_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAME_BITS  (FRAME_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a word while busy");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load, cmd.exec, cmd.shift, cmd.finish}))
        else $error("more than one command at once");

    a_finish_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_tvalid || m_tready))
        else $error("result overwrote a pending word");

    a_finish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_tvalid)
        else $error("finished word not presented");

endmodule

`default_nettype wire
